// ===== design/mmqs_pkg.sv =====
// Shared types, constants and a helper function of the moving min/max quantization observer.
`timescale 1ns / 1ps

package mmqs_pkg;

  // Sample width of the Q8.8 input stream.
  localparam int SampleBits = 16;

  // Widths of the Q8.16 moving values, the scale and the zero point.
  localparam int Q816Width  = 24;
  localparam int ScaleWidth = 40;
  localparam int ZpWidth    = 32;

  // Configuration port.
  localparam int CfgIdxWidth  = 2;
  localparam int CfgDataWidth = 17;
  localparam int BitsWidth    = 5;
  localparam int MomWidth     = 17;

  localparam logic [CfgIdxWidth-1:0] CfgAffineMode = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CfgTargetBits = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CfgMomentum   = 2'd2;

  localparam logic [BitsWidth-1:0] BitsReset = 5'd8;
  localparam logic [BitsWidth-1:0] BitsMin   = 5'd2;
  localparam logic [BitsWidth-1:0] BitsMax   = 5'd16;
  localparam logic [MomWidth-1:0]  MomReset  = 17'd62259;
  localparam logic [MomWidth-1:0]  MomOne    = 17'h10000;

  // Iterative divider: dividend and divisor widths.
  localparam int DivWidth    = 48;
  localparam int DivorWidth  = ScaleWidth;
  localparam int DivCntWidth = $clog2(DivWidth);

  // Saturation limits of the Q8.16 moving values.
  localparam logic signed [Q816Width-1:0] Q816Max = 24'sh7fffff;
  localparam logic signed [Q816Width-1:0] Q816Min = -24'sh800000;

  // Request payloads.
  typedef struct packed {
    logic signed [SampleBits-1:0] sample;
    logic                         last_sample;
  } in_req_t;

  typedef struct packed {
    logic        [ScaleWidth-1:0] scale_out;
    logic signed [ZpWidth-1:0]    zero_offset;
    logic signed [Q816Width-1:0]  avg_max;
    logic signed [Q816Width-1:0]  avg_min;
    logic                         clipped;
  } out_req_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;      // an input request is taken this cycle
    logic mul_first;   // old value times momentum into the accumulator
    logic mul_second;  // add batch value times one minus momentum
    logic mul_low;     // blend works on the minimum instead of the maximum
    logic wr_high;     // write the blended maximum
    logic wr_low;      // write the blended minimum
    logic div_scale;   // start the scale division
    logic div_zp;      // start the zero point division
    logic take_scale;  // latch the scale quotient
    logic take_zp;     // latch and saturate the zero point quotient
    logic load_out;    // move the finished result into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic affine;
    logic div_done;
    logic quo_zero;
    logic out_free;
  } ctrl_sts_t;

  // Q8.8 value (already extended by two bits) to Q8.16, saturated.
  function automatic logic signed [Q816Width-1:0] to_q816(
    input logic signed [SampleBits+1:0] v
  );
    logic signed [SampleBits+9:0] w;
    logic signed [Q816Width-1:0]  r;
    w = $signed({v, 8'h00});
    if (w > Q816Max) begin
      r = Q816Max;
    end else if (w < Q816Min) begin
      r = Q816Min;
    end else begin
      r = w[Q816Width-1:0];
    end
    return r;
  endfunction

endpackage

// ===== design/mmqs_divider.sv =====
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module mmqs_divider (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic [mmqs_pkg::DivWidth-1:0]         dividend_i,
  input  logic [mmqs_pkg::DivorWidth-1:0]       divisor_i,
  output logic [mmqs_pkg::DivWidth-1:0]         quotient_o,
  output logic                                  done_o
);

  localparam int DW = mmqs_pkg::DivWidth;
  localparam int VW = mmqs_pkg::DivorWidth;
  localparam int CW = mmqs_pkg::DivCntWidth;

  logic [VW:0]   rem_q;
  logic [DW-1:0] quo_q;
  logic [VW-1:0] divisor_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;

  logic [VW:0]   rem_sh;
  logic [VW+1:0] diff;
  logic          fits;

  // Trial subtraction of the divisor from the shifted partial remainder.
  assign rem_sh = {rem_q[VW-1:0], quo_q[DW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, divisor_q};
  assign fits   = ~diff[VW+1];

  // Control: busy while bits remain, done pulses after the last bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DW - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  // Datapath: dividend shifts out at the top while quotient bits shift in.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q     <= '0;
      quo_q     <= dividend_i;
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[VW:0] : rem_sh;
      quo_q <= {quo_q[DW-2:0], fits};
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

// ===== design/mmqs_datapath.sv =====
// Datapath: configuration registers, batch extremes, moving averages, divisions, result register.
`timescale 1ns / 1ps

module mmqs_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [mmqs_pkg::CfgIdxWidth-1:0]     cfg_index_i,
  input  logic [mmqs_pkg::CfgDataWidth-1:0]    cfg_data_i,
  input  mmqs_pkg::in_req_t                    in_data_i,
  output mmqs_pkg::out_req_t                   out_data_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  input  mmqs_pkg::ctrl_cmd_t                  cmd_i,
  output mmqs_pkg::ctrl_sts_t                  sts_o
);

  localparam int SB = mmqs_pkg::SampleBits;
  localparam int QW = mmqs_pkg::Q816Width;
  localparam int MW = mmqs_pkg::MomWidth;
  localparam int PW = QW + MW + 1;
  localparam int AW = PW + 2;
  localparam int DW = mmqs_pkg::DivWidth;
  localparam int VW = mmqs_pkg::DivorWidth;
  localparam int SW = mmqs_pkg::ScaleWidth;
  localparam int ZW = mmqs_pkg::ZpWidth;

  // Configuration registers.
  logic                              affine_q;
  logic [mmqs_pkg::BitsWidth-1:0]    bits_q;
  logic [MW-1:0]                     mom_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      affine_q <= 1'b0;
      bits_q   <= mmqs_pkg::BitsReset;
      mom_q    <= mmqs_pkg::MomReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        mmqs_pkg::CfgAffineMode: affine_q <= cfg_data_i[0];
        mmqs_pkg::CfgTargetBits: bits_q   <= cfg_data_i[mmqs_pkg::BitsWidth-1:0];
        mmqs_pkg::CfgMomentum:   mom_q    <= cfg_data_i[MW-1:0];
        default: ;
      endcase
    end
  end

  // Batch extremes including the sample taken this cycle.
  logic signed [SB-1:0] bhigh_q, blow_q;
  logic                 started_q;
  logic signed [SB-1:0] s, nhigh, nlow;

  assign s     = in_data_i.sample;
  assign nhigh = (!started_q || s > bhigh_q) ? s : bhigh_q;
  assign nlow  = (!started_q || s < blow_q) ? s : blow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bhigh_q   <= '0;
      blow_q    <= '0;
      started_q <= 1'b0;
    end else if (cmd_i.accept) begin
      bhigh_q   <= nhigh;
      blow_q    <= nlow;
      started_q <= ~in_data_i.last_sample;
    end
  end

  // Batch values in Q8.16: the larger magnitude in symmetric mode.
  logic signed [SB+1:0]  ehigh, elow, ahigh, alow, amax;
  logic signed [QW-1:0]  act_hi_d, act_lo_d;
  logic signed [QW-1:0]  act_hi_q, act_lo_q;

  assign ehigh    = (SB + 2)'(nhigh);
  assign elow     = (SB + 2)'(nlow);
  assign ahigh    = ehigh[SB+1] ? -ehigh : ehigh;
  assign alow     = elow[SB+1] ? -elow : elow;
  assign amax     = (ahigh > alow) ? ahigh : alow;
  assign act_hi_d = mmqs_pkg::to_q816(affine_q ? ehigh : amax);
  assign act_lo_d = mmqs_pkg::to_q816(elow);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && in_data_i.last_sample) begin
      act_hi_q <= act_hi_d;
      act_lo_q <= act_lo_d;
    end
  end

  // Exponential average: one shared multiplier, two products accumulated.
  logic signed [QW-1:0] run_hi_q, run_lo_q;
  logic signed [QW-1:0] old_sel, act_sel;
  logic [MW-1:0]        m_eff, mul_b;
  logic signed [PW-1:0] prod;
  logic signed [AW-1:0] acc_q;

  assign m_eff   = (mom_q > mmqs_pkg::MomOne) ? mmqs_pkg::MomOne : mom_q;
  assign mul_b   = cmd_i.mul_first ? m_eff : (mmqs_pkg::MomOne - m_eff);
  assign old_sel = cmd_i.mul_low ? run_lo_q : run_hi_q;
  assign act_sel = cmd_i.mul_low ? act_lo_q : act_hi_q;
  assign prod    = (cmd_i.mul_first ? old_sel : act_sel) * $signed({1'b0, mul_b});

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_first) begin
      acc_q <= AW'(prod) + AW'(32768);
    end else if (cmd_i.mul_second) begin
      acc_q <= acc_q + AW'(prod);
    end
  end

  // Round by the bias already in the accumulator, then saturate.
  logic signed [AW-17:0] shifted;
  logic signed [QW-1:0]  blend_sat, blend_res;

  assign shifted = $signed(acc_q[AW-1:16]);
  always_comb begin
    if (shifted > mmqs_pkg::Q816Max) begin
      blend_sat = mmqs_pkg::Q816Max;
    end else if (shifted < mmqs_pkg::Q816Min) begin
      blend_sat = mmqs_pkg::Q816Min;
    end else begin
      blend_sat = shifted[QW-1:0];
    end
  end
  // A moving value of zero is uninitialized and takes the batch value outright.
  assign blend_res = (old_sel == '0) ? act_sel : blend_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_hi_q <= '0;
      run_lo_q <= '0;
    end else begin
      if (cmd_i.wr_high) begin
        run_hi_q <= blend_res;
        if (!affine_q) begin
          run_lo_q <= blend_res;
        end
      end
      if (cmd_i.wr_low) begin
        run_lo_q <= blend_res;
      end
    end
  end

  // Scale divisor 2^e - 1, with the bit width clamped to its legal range.
  logic [mmqs_pkg::BitsWidth-1:0] b_eff, e_sh;
  logic [MW-1:0]                  den;

  assign b_eff = (bits_q < mmqs_pkg::BitsMin) ? mmqs_pkg::BitsMin :
                 (bits_q > mmqs_pkg::BitsMax) ? mmqs_pkg::BitsMax : bits_q;
  assign e_sh  = affine_q ? b_eff : (b_eff - 1'b1);
  assign den   = (MW'(1) << e_sh) - MW'(1);

  // Scale numerator: range or maximum, in Q8.16 shifted to Q8.24.
  logic signed [QW:0]    num;
  logic                  num_pos;
  logic [DW-1:0]         sc_dividend;

  assign num         = affine_q ? ((QW + 1)'(run_hi_q) - (QW + 1)'(run_lo_q))
                                : (QW + 1)'(run_hi_q);
  assign num_pos     = ~num[QW] && (num != '0);
  assign sc_dividend = num_pos ? (DW'({num[QW-1:0], 8'h00}) + DW'(den >> 1)) : '0;

  // Zero point numerator: magnitude of the minimum plus half the scale.
  logic signed [QW-1:0]  lo_abs;
  logic [SW-1:0]         scale_q;
  logic [DW-1:0]         zp_dividend;

  assign lo_abs      = run_lo_q[QW-1] ? -run_lo_q : run_lo_q;
  assign zp_dividend = DW'({lo_abs, 16'h0000}) + DW'(scale_q >> 1);

  // Shared iterative divider.
  logic [DW-1:0] div_dividend, quo;
  logic [VW-1:0] div_divisor;
  logic          div_done;

  assign div_dividend = cmd_i.div_scale ? sc_dividend : zp_dividend;
  assign div_divisor  = cmd_i.div_scale ? VW'(den) : VW'(scale_q);

  mmqs_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_scale | cmd_i.div_zp),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (quo),
    .done_o     (div_done)
  );

  // Scale, zero point and clip flag.
  logic signed [ZW-1:0] zp_q;
  logic                 clip_q;
  logic                 zp_neg;
  logic [ZW:0]          q_sat;
  logic                 q_clip;

  assign zp_neg = ~run_lo_q[QW-1] && (run_lo_q != '0);

  always_comb begin
    if (zp_neg) begin
      q_clip = quo > DW'(33'h080000000);
      q_sat  = q_clip ? 33'h080000000 : quo[ZW:0];
    end else begin
      q_clip = quo > DW'(33'h07fffffff);
      q_sat  = q_clip ? 33'h07fffffff : quo[ZW:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_scale) begin
      scale_q <= quo[SW-1:0];
      zp_q    <= '0;
      clip_q  <= (quo == '0);
    end else if (cmd_i.take_zp) begin
      zp_q   <= zp_neg ? -$signed(q_sat[ZW-1:0]) : $signed(q_sat[ZW-1:0]);
      clip_q <= q_clip;
    end
  end

  // Output register: holds a finished result until the consumer takes it.
  logic               out_valid_q;
  mmqs_pkg::out_req_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.scale_out   <= scale_q;
      out_q.zero_offset <= zp_q;
      out_q.avg_max     <= run_hi_q;
      out_q.avg_min     <= run_lo_q;
      out_q.clipped     <= clip_q;
    end
  end

  assign out_data_o  = out_q;
  assign out_valid_o = out_valid_q;

  // Status toward the controller.
  assign sts_o.affine   = affine_q;
  assign sts_o.div_done = div_done;
  assign sts_o.quo_zero = (quo == '0);
  assign sts_o.out_free = ~out_valid_q | out_ready_i;

endmodule

// ===== design/mmqs_ctrl.sv =====
// Controller state machine that sequences the end-of-batch update.
`timescale 1ns / 1ps

module mmqs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_last_i,
  output logic                 in_ready_o,
  input  mmqs_pkg::ctrl_sts_t  sts_i,
  output mmqs_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [11:0] {
    S_IDLE     = 12'b000000000001,
    S_HI_OLD   = 12'b000000000010,
    S_HI_ACT   = 12'b000000000100,
    S_HI_WR    = 12'b000000001000,
    S_LO_OLD   = 12'b000000010000,
    S_LO_ACT   = 12'b000000100000,
    S_LO_WR    = 12'b000001000000,
    S_SC_START = 12'b000010000000,
    S_SC_WAIT  = 12'b000100000000,
    S_ZP_START = 12'b001000000000,
    S_ZP_WAIT  = 12'b010000000000,
    S_FINISH   = 12'b100000000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i && in_last_i) begin
          state_d = S_HI_OLD;
        end
      end
      S_HI_OLD: begin
        cmd_o.mul_first = 1'b1;
        state_d = S_HI_ACT;
      end
      S_HI_ACT: begin
        cmd_o.mul_second = 1'b1;
        state_d = S_HI_WR;
      end
      S_HI_WR: begin
        cmd_o.wr_high = 1'b1;
        state_d = sts_i.affine ? S_LO_OLD : S_SC_START;
      end
      S_LO_OLD: begin
        cmd_o.mul_first = 1'b1;
        cmd_o.mul_low   = 1'b1;
        state_d = S_LO_ACT;
      end
      S_LO_ACT: begin
        cmd_o.mul_second = 1'b1;
        cmd_o.mul_low    = 1'b1;
        state_d = S_LO_WR;
      end
      S_LO_WR: begin
        cmd_o.wr_low  = 1'b1;
        cmd_o.mul_low = 1'b1;
        state_d = S_SC_START;
      end
      S_SC_START: begin
        cmd_o.div_scale = 1'b1;
        state_d = S_SC_WAIT;
      end
      S_SC_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.take_scale = 1'b1;
          state_d = (sts_i.quo_zero || !sts_i.affine) ? S_FINISH : S_ZP_START;
        end
      end
      S_ZP_START: begin
        cmd_o.div_zp = 1'b1;
        state_d = S_ZP_WAIT;
      end
      S_ZP_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.take_zp = 1'b1;
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

// ===== design/moving_minmax_quant_scale_unit.sv =====
// Top level of the moving min/max quantization observer.
`timescale 1ns / 1ps

// Samples in signed Q8.8 are taken one per cycle while the block is collecting a
// batch; the request that carries last_sample closes the batch and the block then
// stops taking requests while it folds the batch extremes into the moving maximum
// and minimum and works out the scale and zero point. The moving averages run on
// one shared multiplier, and both divisions use one restoring divider that yields
// one quotient bit per cycle. In symmetric mode the zero point division is skipped,
// and in affine mode it is skipped when the scale is zero; the result then sits in
// an output register, so the next batch streams in while it waits to be taken.
// Configuration is written through a plain write port; the user must write it only
// while the block is idle, as the block itself does not enforce this.
module moving_minmax_quant_scale_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mmqs_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [mmqs_pkg::CfgDataWidth-1:0] cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  mmqs_pkg::in_req_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output mmqs_pkg::out_req_t                out_data_o
);

  mmqs_pkg::ctrl_cmd_t cmd;
  mmqs_pkg::ctrl_sts_t sts;

  // Sequencer.
  mmqs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_data_i.last_sample),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Arithmetic and storage.
  mmqs_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
